// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, muted while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Signal must keep its value in the cycle after the antecedent.
`define ASSERT_HOLD(label, ante, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C master bit engine package
// Item types, command codes and default queue depths.
// ---------------------------------------------------------------------------
package i2cm_pkg;

  // Input function codes
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  localparam int I2CM_MID_DEPTH = 2;
  localparam int I2CM_OUT_DEPTH = 2;

  // Classified operation carried from front to back
  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ
  } op_t;

  // Command in progress in the back end
  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] wr_byte;
    logic       send_ack;
    logic       scl_level;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] wr_byte;
    logic       send_ack;
    logic       scl_level;
    logic       sda_level;
  } mid_item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       cmd_done;
    logic [7:0] rd_byte;
    logic       ack_seen;
  } out_item_t;

endpackage

// ===== rtl/i2cm_queue.sv =====
// ---------------------------------------------------------------------------
// I2C master small queue
// Register-based first-in first-out queue with full and empty flags.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `ASSERT_NEXT(a_q_fill, push_ok && !pop_ok, count_r == $past(count_r) + CW'(1), "queue count did not grow on push")

endmodule

// ===== rtl/i2cm_front.sv =====
// ---------------------------------------------------------------------------
// I2C master front end
// Accept input items, classify the function code and queue them for the back.
// ---------------------------------------------------------------------------
module i2cm_front
  import i2cm_pkg::*;
#(
  parameter int MID_DEPTH = I2CM_MID_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      mid_empty,
  input  logic      mid_pop,
  output mid_item_t mid_item
);

  mid_item_t cls_item;

  // Unused function codes fall through as ticks.
  always_comb begin
    cls_item.wr_byte   = in_item.wr_byte;
    cls_item.send_ack  = in_item.send_ack;
    cls_item.scl_level = in_item.scl_level;
    cls_item.sda_level = in_item.sda_level;
    case (in_item.func)
      FUNC_START: cls_item.op = OP_START;
      FUNC_STOP:  cls_item.op = OP_STOP;
      FUNC_WRITE: cls_item.op = OP_WRITE;
      FUNC_READ:  cls_item.op = OP_READ;
      FUNC_TICK:  cls_item.op = OP_TICK;
      default:    cls_item.op = OP_TICK;
    endcase
  end

  i2cm_queue #(
    .WIDTH($bits(mid_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .full (in_full),
    .wdata(cls_item),
    .pop  (mid_pop),
    .empty(mid_empty),
    .rdata(mid_item)
  );

endmodule

// ===== rtl/i2cm_back.sv =====
// ---------------------------------------------------------------------------
// I2C master back end
// Advance the active command by up to one pin phase per item and queue the resulting line state.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_back
  import i2cm_pkg::*;
#(
  parameter int OUT_DEPTH = I2CM_OUT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mid_empty,
  output logic      mid_pop,
  input  mid_item_t mid_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  cmd_t       cmd_r, cmd_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [3:0] bc_r, bc_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       ackc_r, ackc_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ackr_r, ackr_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic       done;
  logic       out_full;
  out_item_t  res;

  assign mid_pop = !mid_empty && !out_full;

  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    shift_nxt = shift_r;
    ackc_nxt  = ackc_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ackr_nxt  = ackr_r;
    rd_nxt    = rd_r;
    done      = 1'b0;
    if (mid_pop) begin
      // Take a new command only while idle; otherwise it acts as a tick.
      if (cmd_r == CMD_IDLE) begin
        case (mid_item.op)
          OP_START: cmd_nxt = CMD_START;
          OP_STOP:  cmd_nxt = CMD_STOP;
          OP_WRITE: cmd_nxt = CMD_WRITE;
          OP_READ:  cmd_nxt = CMD_READ;
          default:  cmd_nxt = CMD_IDLE;
        endcase
        phase_nxt = 3'd0;
        bc_nxt    = 4'd0;
        if (mid_item.op == OP_WRITE) begin
          shift_nxt = mid_item.wr_byte;
        end
        if (mid_item.op == OP_READ) begin
          ackc_nxt = mid_item.send_ack;
        end
      end
      case (cmd_nxt)
        CMD_START: begin
          case (phase_nxt)
            3'd0:    sda_nxt = 1'b1;
            3'd1:    scl_nxt = 1'b1;
            3'd2:    sda_nxt = 1'b0;
            default: begin
              scl_nxt = 1'b0;
              done    = 1'b1;
            end
          endcase
          phase_nxt = phase_nxt + 3'd1;
        end
        CMD_STOP: begin
          case (phase_nxt)
            3'd0:    sda_nxt = 1'b0;
            3'd1:    scl_nxt = 1'b1;
            default: begin
              sda_nxt = 1'b1;
              done    = 1'b1;
            end
          endcase
          phase_nxt = phase_nxt + 3'd1;
        end
        CMD_WRITE: begin
          case (phase_nxt)
            3'd0: begin
              sda_nxt   = shift_nxt[7];
              phase_nxt = 3'd1;
            end
            3'd1: begin
              scl_nxt   = 1'b1;
              phase_nxt = 3'd2;
            end
            3'd2: begin
              scl_nxt   = 1'b0;
              shift_nxt = {shift_nxt[6:0], 1'b0};
              bc_nxt    = bc_nxt + 4'd1;
              phase_nxt = (bc_nxt >= 4'd8) ? 3'd3 : 3'd0;
            end
            3'd3: begin
              sda_nxt   = 1'b1;
              phase_nxt = 3'd4;
            end
            3'd4: begin
              scl_nxt   = 1'b1;
              phase_nxt = 3'd5;
            end
            default: begin
              ackr_nxt = mid_item.sda_level;
              scl_nxt  = 1'b0;
              done     = 1'b1;
            end
          endcase
        end
        CMD_READ: begin
          case (phase_nxt)
            3'd0: begin
              sda_nxt   = 1'b1;
              shift_nxt = 8'd0;
              bc_nxt    = 4'd0;
              phase_nxt = 3'd1;
            end
            3'd1: begin
              scl_nxt   = 1'b1;
              phase_nxt = 3'd2;
            end
            3'd2: begin
              // Hold while the target stretches the clock.
              if (mid_item.scl_level) begin
                shift_nxt = {shift_nxt[6:0], mid_item.sda_level};
                scl_nxt   = 1'b0;
                bc_nxt    = bc_nxt + 4'd1;
                phase_nxt = (bc_nxt >= 4'd8) ? 3'd3 : 3'd1;
              end
            end
            3'd3: begin
              sda_nxt   = !ackc_nxt;
              phase_nxt = 3'd4;
            end
            3'd4: begin
              scl_nxt   = 1'b1;
              phase_nxt = 3'd5;
            end
            3'd5: begin
              scl_nxt   = 1'b0;
              phase_nxt = 3'd6;
            end
            default: begin
              sda_nxt = 1'b1;
              rd_nxt  = shift_nxt;
              done    = 1'b1;
            end
          endcase
        end
        default: begin
        end
      endcase
      if (done) begin
        cmd_nxt   = CMD_IDLE;
        phase_nxt = 3'd0;
        bc_nxt    = 4'd0;
      end
    end
  end

  always_comb begin
    res.scl_drive = scl_nxt;
    res.sda_drive = sda_nxt;
    res.busy_res  = (cmd_nxt != CMD_IDLE);
    res.cmd_done  = done;
    res.rd_byte   = rd_nxt;
    res.ack_seen  = ackr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_IDLE;
      phase_r <= 3'd0;
      bc_r    <= 4'd0;
      shift_r <= 8'd0;
      ackc_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ackr_r  <= 1'b0;
      rd_r    <= 8'd0;
    end else begin
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      shift_r <= shift_nxt;
      ackc_r  <= ackc_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ackr_r  <= ackr_nxt;
      rd_r    <= rd_nxt;
    end
  end

  i2cm_queue #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_pop),
    .full (out_full),
    .wdata(res),
    .pop  (out_pop),
    .empty(out_empty),
    .rdata(out_item)
  );

  `ASSERT_HOLD(a_idle_tick, mid_pop && cmd_r == CMD_IDLE && mid_item.op == OP_TICK, {scl_r, sda_r}, "idle tick moved the lines")
  `ASSERT_NEXT(a_stretch, mid_pop && cmd_r == CMD_READ && phase_r == 3'd2 && !mid_item.scl_level, cmd_r == CMD_READ && phase_r == 3'd2, "read left stretch wait")
  `ASSERT_NEXT(a_wr_last, mid_pop && cmd_r == CMD_WRITE && phase_r == 3'd2 && bc_r == 4'd7, phase_r == 3'd3, "write missed ACK slot")

endmodule

// ===== rtl/i2c_master_bit_engine_top.sv =====
// An accepted item is registered in the middle queue, then the engine result is registered in the result queue.
// Throughput: one item per cycle while the result queue has room; the engine advances up to one pin phase per item.
// The engine state update loop is closed within one register stage.
// Reset: synchronous on rst_n low; both queues empty, engine idle, SCL and SDA released.
// ---------------------------------------------------------------------------
// I2C master bit engine
// Queue-fronted I2C line engine: up to one pin phase and one result per item.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_top
  import i2cm_pkg::*;
#(
  parameter int MID_DEPTH = I2CM_MID_DEPTH,
  parameter int OUT_DEPTH = I2CM_OUT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  // input item channel
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  // result item channel
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  // Classified items waiting between front and back.
  logic      mid_empty;
  logic      mid_pop;
  mid_item_t mid_item;

  // Front: accept items, map function codes to operations (unused codes
  // become ticks) and hold them in a short queue. Commands are not checked
  // against the busy state here; the back decides whether one is taken.
  i2cm_front #(
    .MID_DEPTH(MID_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .mid_empty(mid_empty),
    .mid_pop  (mid_pop),
    .mid_item (mid_item)
  );

  // Back: pop one item whenever the result queue has room, advance the
  // active command by up to one phase and push the resulting line state. The
  // result queue lets the engine run on while the consumer stalls.
  i2cm_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mid_empty(mid_empty),
    .mid_pop  (mid_pop),
    .mid_item (mid_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives pin-phase items through the queue front end of the line engine and
// checks every reported pin state against a cycle-free model of the engine.
// A short table of hand-picked items comes first. Random command sequences
// follow, with clock stretching, ignored commands and stray codes among them.
// ---------------------------------------------------------------------------
module testbench;
  import i2cm_pkg::*;

  // Codes above the read command act as ticks
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  localparam int RANDOM_PHASES  = 1070; // phases run by the random part
  localparam int HOLD_AFTER     = 300;  // results taken before the long hold-off
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 8;    // margin after the last awaited report
  localparam int WATCHDOG_LIMIT = 1500;
  localparam int REPORT_LIMIT   = 10;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  i2c_master_bit_engine_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // -------------------------------------------------------------------------
  // Model of the line engine: its own copy of the phase state
  // -------------------------------------------------------------------------
  cmd_t       line_cmd;
  logic [2:0] line_phase;
  logic [3:0] line_bits;
  logic [7:0] line_shift;
  logic       line_ack_choice;
  logic       line_scl;
  logic       line_sda;
  logic       line_ack;
  logic [7:0] line_rd_byte;

  // Pin reports awaited from the block, oldest first
  out_item_t pending_pins [$];

  int mismatches;
  int items_offered;
  int phases_run;
  int results_taken;
  int stretch_holds;
  int cmds_done [cmd_t];

  // Advance the model by one item and work out the pin report it causes.
  task automatic advance_line_engine(input in_item_t it, output out_item_t rep,
                                     output bit stepped);
    logic done;
    done = 1'b0;
    // Accept a command only while idle; anything else acts as a tick
    if (line_cmd == CMD_IDLE) begin
      case (it.func)
        FUNC_START: line_cmd = CMD_START;
        FUNC_STOP:  line_cmd = CMD_STOP;
        FUNC_WRITE: begin
          line_cmd = CMD_WRITE;
          line_shift = it.wr_byte;
        end
        FUNC_READ: begin
          line_cmd = CMD_READ;
          line_ack_choice = it.send_ack;
        end
        default: ;
      endcase
      line_phase = 3'd0;
      line_bits = 4'd0;
    end
    stepped = (line_cmd != CMD_IDLE);
    case (line_cmd)
      CMD_START: begin
        case (line_phase)
          3'd0: line_sda = 1'b1;
          3'd1: line_scl = 1'b1;
          3'd2: line_sda = 1'b0;
          default: begin
            line_scl = 1'b0;
            done = 1'b1;
          end
        endcase
        line_phase = line_phase + 3'd1;
      end
      CMD_STOP: begin
        case (line_phase)
          3'd0: line_sda = 1'b0;
          3'd1: line_scl = 1'b1;
          default: begin
            line_sda = 1'b1;
            done = 1'b1;
          end
        endcase
        line_phase = line_phase + 3'd1;
      end
      CMD_WRITE: begin
        case (line_phase)
          3'd0: begin
            line_sda = line_shift[7];
            line_phase = 3'd1;
          end
          3'd1: begin
            line_scl = 1'b1;
            line_phase = 3'd2;
          end
          3'd2: begin
            line_scl = 1'b0;
            line_shift = {line_shift[6:0], 1'b0};
            line_bits = line_bits + 4'd1;
            line_phase = (line_bits >= 4'd8) ? 3'd3 : 3'd0;
          end
          3'd3: begin
            line_sda = 1'b1;
            line_phase = 3'd4;
          end
          3'd4: begin
            line_scl = 1'b1;
            line_phase = 3'd5;
          end
          default: begin
            line_ack = it.sda_level;
            line_scl = 1'b0;
            done = 1'b1;
          end
        endcase
      end
      CMD_READ: begin
        case (line_phase)
          3'd0: begin
            line_sda = 1'b1;
            line_shift = 8'h00;
            line_bits = 4'd0;
            line_phase = 3'd1;
          end
          3'd1: begin
            line_scl = 1'b1;
            line_phase = 3'd2;
          end
          3'd2: begin
            // Hold while the target stretches SCL low
            if (!it.scl_level) begin
              stretch_holds++;
            end else begin
              line_shift = {line_shift[6:0], it.sda_level};
              line_scl = 1'b0;
              line_bits = line_bits + 4'd1;
              line_phase = (line_bits >= 4'd8) ? 3'd3 : 3'd1;
            end
          end
          3'd3: begin
            line_sda = ~line_ack_choice;
            line_phase = 3'd4;
          end
          3'd4: begin
            line_scl = 1'b1;
            line_phase = 3'd5;
          end
          3'd5: begin
            line_scl = 1'b0;
            line_phase = 3'd6;
          end
          default: begin
            line_sda = 1'b1;
            line_rd_byte = line_shift;
            done = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
    if (done) begin
      cmds_done[line_cmd] = cmds_done[line_cmd] + 1;
      line_cmd = CMD_IDLE;
      line_phase = 3'd0;
      line_bits = 4'd0;
    end
    rep.scl_drive = line_scl;
    rep.sda_drive = line_sda;
    rep.busy_res  = (line_cmd != CMD_IDLE);
    rep.cmd_done  = done;
    rep.rd_byte   = line_rd_byte;
    rep.ack_seen  = line_ack;
  endtask

  // -------------------------------------------------------------------------
  // Sender: offer one item, idling first for a random gap unless in a burst
  // -------------------------------------------------------------------------
  bit tx_burst;

  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t typed_rep);
    int        gap;
    out_item_t rep;
    bit        stepped;
    if (items_offered % 48 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    // Wait for the block to take the item; full is read before the edge updates it
    do @(posedge clk); while (in_full);
    advance_line_engine(it, rep, stepped);
    pending_pins.push_back(typed ? typed_rep : rep);
    items_offered++;
    if (stepped) phases_run++;
    @(negedge clk);
  endtask

  // Random tick: mostly plain ticks, some commands that the busy engine drops
  // and some stray codes; SCL sampled low now and then so reads stretch.
  function automatic in_item_t random_tick();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) it.func = FUNC_TICK;
    else if (pick < 90) it.func = 3'($urandom_range(FUNC_READ, FUNC_START));
    else it.func = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
    it.wr_byte   = 8'($urandom);
    it.send_ack  = 1'($urandom_range(0, 1));
    it.scl_level = ($urandom_range(0, 3) != 0);
    it.sda_level = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // -------------------------------------------------------------------------
  // Receiver: take reports with random gaps, one long hold-off, and check
  // -------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch on report %0d, %s: expected %h, got %h",
                 results_taken, name, want, got);
    end
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (pending_pins.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("report %0d arrived with nothing awaited: %h", results_taken, got);
    end else begin
      want = pending_pins.pop_front();
      compare_field("scl_drive", 8'(want.scl_drive), 8'(got.scl_drive));
      compare_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
      compare_field("busy_res",  8'(want.busy_res),  8'(got.busy_res));
      compare_field("cmd_done",  8'(want.cmd_done),  8'(got.cmd_done));
      compare_field("rd_byte",   want.rd_byte,       got.rd_byte);
      compare_field("ack_seen",  8'(want.ack_seen),  8'(got.ack_seen));
    end
  endtask

  bit rx_burst;
  bit hold_given;

  initial begin
    int gap;
    out_pop = 1'b0;
    hold_given = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (results_taken % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      // Hold off once for a long stretch so the queues fill and in_full rises
      if (!hold_given && results_taken == HOLD_AFTER) begin
        hold_given = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 16);
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      check_report(out_item);
      results_taken++;
      @(negedge clk);
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves on either side for too long
  // -------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Directed table: hand-picked items, a few with the report typed in
  // -------------------------------------------------------------------------
  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  localparam int PLAN_ROWS = 17;
  plan_row_t plan [PLAN_ROWS];

  initial begin
    in_item_t it;
    int       r;
    int unsigned pick;

    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    tx_burst = 1'b0;
    mismatches = 0;

    // Engine after reset: idle, both lines released
    line_cmd = CMD_IDLE;
    line_phase = 3'd0;
    line_bits = 4'd0;
    line_shift = 8'h00;
    line_ack_choice = 1'b0;
    line_scl = 1'b1;
    line_sda = 1'b1;
    line_ack = 1'b0;
    line_rd_byte = 8'h00;

    plan = '{
      // idle tick and a stray code straight after reset: nothing moves
      '{'{FUNC_TICK,     8'h00, 1'b0, 1'b0, 1'b0}, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      '{'{FUNC_SPARE_HI, 8'hFF, 1'b1, 1'b1, 1'b1}, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      // start condition, with a write dropped while it runs
      '{'{FUNC_START,    8'h00, 1'b0, 1'b1, 1'b1}, 1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{'{FUNC_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{'{FUNC_WRITE,    8'hFF, 1'b1, 1'b1, 1'b1}, 1, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{'{FUNC_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
      // write of all ones, target leaves SDA high in the ACK slot
      '{'{FUNC_WRITE,    8'hFF, 1'b0, 1'b1, 1'b1}, 1,  1'b0, '0},
      '{'{FUNC_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 26, 1'b0, '0},
      // read with ACK, stretched on the first bit, a stray code part way
      '{'{FUNC_READ,     8'h00, 1'b1, 1'b1, 1'b1}, 1,  1'b0, '0},
      '{'{FUNC_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 1,  1'b0, '0},
      '{'{FUNC_TICK,     8'h00, 1'b0, 1'b0, 1'b0}, 3,  1'b0, '0},
      '{'{FUNC_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 10, 1'b0, '0},
      '{'{FUNC_SPARE_LO, 8'h00, 1'b0, 1'b1, 1'b0}, 1,  1'b0, '0},
      '{'{FUNC_TICK,     8'h00, 1'b0, 1'b1, 1'b0}, 9,  1'b0, '0},
      // stop condition, then an idle tick
      '{'{FUNC_STOP,     8'h00, 1'b0, 1'b1, 1'b1}, 1,  1'b0, '0},
      '{'{FUNC_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 2,  1'b0, '0},
      '{'{FUNC_TICK,     8'h00, 1'b0, 1'b1, 1'b1}, 1,  1'b0, '0}
    };

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < PLAN_ROWS; r++)
      repeat (plan[r].reps) offer_item(plan[r].item, plan[r].typed, plan[r].want);

    // Random part: mostly whole commands clocked through to completion,
    // with short bursts of arbitrary items that may break into a sequence
    phases_run = 0;
    while (phases_run < RANDOM_PHASES) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        case ($urandom_range(0, 3))
          0:       it.func = FUNC_START;
          1:       it.func = FUNC_STOP;
          2:       it.func = FUNC_WRITE;
          default: it.func = FUNC_READ;
        endcase
        it.wr_byte   = 8'($urandom);
        it.send_ack  = 1'($urandom_range(0, 1));
        it.scl_level = 1'($urandom_range(0, 1));
        it.sda_level = 1'($urandom_range(0, 1));
        offer_item(it, 1'b0, '0);
        while (line_cmd != CMD_IDLE) offer_item(random_tick(), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          it = in_item_t'($urandom);
          offer_item(it, 1'b0, '0);
        end
      end
    end
    in_push <= 1'b0;

    // Drain: wait for every awaited report, then wait on for a margin to catch extras
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items, %0d reports; commands done: %0d start, %0d stop, %0d write,",
             items_offered, results_taken, cmds_done[CMD_START], cmds_done[CMD_STOP],
             cmds_done[CMD_WRITE]);
    $display("  %0d read, %0d stretch holds; %0d mismatches",
             cmds_done[CMD_READ], stretch_holds, mismatches);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
